@@ src/plwc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package plwc_pkg;

  // pilot level classes, also the published state codes
  typedef enum logic [2:0] {
    CLS_A = 3'd0,
    CLS_B = 3'd1,
    CLS_C = 3'd2,
    CLS_D = 3'd3,
    CLS_F = 3'd4,
    CLS_T = 3'd5
  } class_t;

  localparam int NUM_CLASSES = 6;

  // configuration register indexes
  localparam logic [2:0] REG_A_MIN     = 3'd0;
  localparam logic [2:0] REG_B_MIN     = 3'd1;
  localparam logic [2:0] REG_C_MIN     = 3'd2;
  localparam logic [2:0] REG_D_MIN     = 3'd3;
  localparam logic [2:0] REG_FAULT_MAX = 3'd4;
  localparam logic [2:0] REG_REPUBLISH = 3'd5;

  // configuration reset values
  localparam logic [7:0] RST_A_MIN     = 8'd232;
  localparam logic [7:0] RST_B_MIN     = 8'd207;
  localparam logic [7:0] RST_C_MIN     = 8'd188;
  localparam logic [7:0] RST_D_MIN     = 8'd170;
  localparam logic [7:0] RST_FAULT_MAX = 8'd104;
  localparam logic [5:0] RST_REPUBLISH = 6'd40;

  // level thresholds handed to the classifier
  typedef struct packed {
    logic [7:0] a_min;
    logic [7:0] b_min;
    logic [7:0] c_min;
    logic [7:0] d_min;
    logic [7:0] fault_max;
  } thresh_t;

  // one window decision handed to the output register
  typedef struct packed {
    logic   valid;
    class_t state;
    logic   periodic;
  } result_t;

endpackage

`default_nettype wire

@@ src/pilot_level_window_classifier_unit.sv @@
// a window's result enters the result register as its last sample leaves the input register
// throughput: one sample per cycle; the input stage waits only while a result is held
// a result occupies the output register until taken, at most one per window
// reset: synchronous active low, clears counts, window position and publish state,
// sets the state to transient and reloads the default thresholds and republish period
`timescale 1ns / 1ps
`default_nettype none

module pilot_level_window_classifier_unit #(
  parameter int WINDOW_SIZE = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_sample,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_pilot_state,
  output logic            out_periodic,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  plwc_pkg::thresh_t thresh_r;
  logic [5:0]        rep_r;
  logic              s1_valid_r;
  logic [7:0]        s1_sample_r;
  logic              out_valid_r;
  logic [2:0]        out_state_r;
  logic              out_periodic_r;
  logic              adv;
  logic              fire;
  plwc_pkg::class_t  cls;
  plwc_pkg::result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r.a_min     <= plwc_pkg::RST_A_MIN;
      thresh_r.b_min     <= plwc_pkg::RST_B_MIN;
      thresh_r.c_min     <= plwc_pkg::RST_C_MIN;
      thresh_r.d_min     <= plwc_pkg::RST_D_MIN;
      thresh_r.fault_max <= plwc_pkg::RST_FAULT_MAX;
      rep_r              <= plwc_pkg::RST_REPUBLISH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        plwc_pkg::REG_A_MIN:     thresh_r.a_min     <= cfg_data;
        plwc_pkg::REG_B_MIN:     thresh_r.b_min     <= cfg_data;
        plwc_pkg::REG_C_MIN:     thresh_r.c_min     <= cfg_data;
        plwc_pkg::REG_D_MIN:     thresh_r.d_min     <= cfg_data;
        plwc_pkg::REG_FAULT_MAX: thresh_r.fault_max <= cfg_data;
        plwc_pkg::REG_REPUBLISH: rep_r              <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // stage advances when the output register is free or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_sample_r <= in_sample;
    end
  end

  plwc_classify u_classify (
    .sample (s1_sample_r),
    .thresh (thresh_r),
    .cls    (cls)
  );

  plwc_decide #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_decide (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (fire),
    .cls         (cls),
    .rep_windows (rep_r),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_state_r    <= res.state;
      out_periodic_r <= res.periodic;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pilot_state = out_state_r;
  assign out_periodic    = out_periodic_r;

`ifndef SYNTHESIS
  // a held sample keeps its value until the stage advances
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_sample_r))
    else $error("input stage lost a held sample");

  // the window step never runs into an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !(out_valid_r && out_stall))
    else $error("window step while result register is blocked");

  // a taken result with no new one leaves the output empty
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !(fire && res.valid) |=> !out_valid_r)
    else $error("result transaction repeated");
`endif

endmodule

`default_nettype wire

@@ src/plwc_classify.sv @@
`timescale 1ns / 1ps
`default_nettype none

module plwc_classify (
  input  wire logic [7:0]        sample,
  input  wire plwc_pkg::thresh_t thresh,
  output plwc_pkg::class_t       cls
);

  // descending threshold tests, first match wins
  always_comb begin
    if (sample >= thresh.a_min) begin
      cls = plwc_pkg::CLS_A;
    end else if (sample >= thresh.b_min) begin
      cls = plwc_pkg::CLS_B;
    end else if (sample >= thresh.c_min) begin
      cls = plwc_pkg::CLS_C;
    end else if (sample >= thresh.d_min) begin
      cls = plwc_pkg::CLS_D;
    end else if (sample <= thresh.fault_max) begin
      cls = plwc_pkg::CLS_F;
    end else begin
      cls = plwc_pkg::CLS_T;
    end
  end

endmodule

`default_nettype wire

@@ src/plwc_decide.sv @@
`timescale 1ns / 1ps
`default_nettype none

module plwc_decide #(
  parameter int WINDOW_SIZE = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire plwc_pkg::class_t cls,
  input  wire logic [5:0]       rep_windows,
  output plwc_pkg::result_t     res
);

  localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
  localparam int POS_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int NEED  = (WINDOW_SIZE * 3 + 3) / 4;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_SIZE - 1);
  localparam logic [CNT_W-1:0] NEED_CNT = CNT_W'(NEED);

  logic [CNT_W-1:0] cnt_r   [plwc_pkg::NUM_CLASSES];
  logic [CNT_W-1:0] cnt_nxt [plwc_pkg::NUM_CLASSES];
  logic [CNT_W-1:0] cnt_inc [plwc_pkg::NUM_CLASSES];
  logic [POS_W-1:0] pos_r, pos_nxt;
  plwc_pkg::class_t cur_r, cur_nxt;
  plwc_pkg::class_t last_r, last_nxt;
  logic             sent_r, sent_nxt;
  logic [5:0]       rep_cnt_r, rep_cnt_nxt;
  logic [5:0]       rep_cnt_plus;
  logic             win_end;
  plwc_pkg::class_t decided;

  // class counts including the current sample
  always_comb begin
    for (int i = 0; i < plwc_pkg::NUM_CLASSES; i++) begin
      cnt_inc[i] = cnt_r[i] + CNT_W'(int'(cls) == i);
    end
  end

  assign win_end = (pos_r == LAST_POS);

  // window decision: rail-to-rail transient, then majority, else hold
  always_comb begin
    if (cnt_inc[plwc_pkg::CLS_B] == '0 && cnt_inc[plwc_pkg::CLS_C] == '0 &&
        cnt_inc[plwc_pkg::CLS_D] == '0 && cnt_inc[plwc_pkg::CLS_A] != '0 &&
        cnt_inc[plwc_pkg::CLS_F] != '0) begin
      decided = plwc_pkg::CLS_T;
    end else if (cnt_inc[plwc_pkg::CLS_A] >= NEED_CNT) begin
      decided = plwc_pkg::CLS_A;
    end else if (cnt_inc[plwc_pkg::CLS_B] >= NEED_CNT) begin
      decided = plwc_pkg::CLS_B;
    end else if (cnt_inc[plwc_pkg::CLS_C] >= NEED_CNT) begin
      decided = plwc_pkg::CLS_C;
    end else if (cnt_inc[plwc_pkg::CLS_D] >= NEED_CNT) begin
      decided = plwc_pkg::CLS_D;
    end else if (cnt_inc[plwc_pkg::CLS_F] >= NEED_CNT) begin
      decided = plwc_pkg::CLS_F;
    end else begin
      decided = cur_r;
    end
  end

  assign rep_cnt_plus = rep_cnt_r + 6'd1;

  // counting, window end and publish control
  always_comb begin
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    cur_nxt     = cur_r;
    last_nxt    = last_r;
    sent_nxt    = sent_r;
    rep_cnt_nxt = rep_cnt_r;
    res         = '{valid: 1'b0, state: cur_r, periodic: 1'b0};
    if (step) begin
      if (!win_end) begin
        cnt_nxt = cnt_inc;
        pos_nxt = pos_r + POS_W'(1);
      end else begin
        for (int i = 0; i < plwc_pkg::NUM_CLASSES; i++) begin
          cnt_nxt[i] = '0;
        end
        pos_nxt   = '0;
        cur_nxt   = decided;
        res.state = decided;
        if (!sent_r || decided != last_r) begin
          res.valid = 1'b1;
          last_nxt  = decided;
          sent_nxt  = 1'b1;
        end else begin
          rep_cnt_nxt = rep_cnt_plus;
          if (rep_cnt_plus >= rep_windows) begin
            res.valid    = 1'b1;
            res.periodic = 1'b1;
            rep_cnt_nxt  = '0;
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < plwc_pkg::NUM_CLASSES; i++) begin
        cnt_r[i] <= '0;
      end
      pos_r     <= '0;
      cur_r     <= plwc_pkg::CLS_T;
      sent_r    <= 1'b0;
      rep_cnt_r <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      pos_r     <= pos_nxt;
      cur_r     <= cur_nxt;
      sent_r    <= sent_nxt;
      rep_cnt_r <= rep_cnt_nxt;
    end
  end

  // last sent state is only read once sent_r is set
  always_ff @(posedge clk) begin
    last_r <= last_nxt;
  end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int WINDOW = 16;
  localparam int MAJORITY = (WINDOW * 3 + 3) / 4;
  localparam int IDLE_PCT = 34;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTED = 10;

  // indexes past the register file, writes there must be ignored
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {
    WIN_MAJORITY,
    WIN_RAIL,
    WIN_RAIL_BROKEN,
    WIN_NOISE
  } window_shape_t;

  typedef struct packed {
    plwc_pkg::class_t state;
    logic             periodic;
  } pilot_report_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_sample;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_pilot_state;
  logic       out_periodic;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  // shadow of the block's registers and window state
  logic [7:0]       lvl_a_min;
  logic [7:0]       lvl_b_min;
  logic [7:0]       lvl_c_min;
  logic [7:0]       lvl_d_min;
  logic [7:0]       lvl_fault_max;
  logic [5:0]       repub_period;
  int               level_count [plwc_pkg::NUM_CLASSES];
  int               window_fill;
  plwc_pkg::class_t held_state;
  plwc_pkg::class_t last_sent;
  bit               published;
  logic [5:0]       repub_count;

  pilot_report_t reports_due [$];
  int            mismatch_count;
  bit            steady_flow;
  int            quiet_cycles;

  pilot_level_window_classifier_unit #(
    .WINDOW_SIZE(WINDOW)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pilot_state(out_pilot_state),
    .out_periodic   (out_periodic),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // window state prediction

  function automatic void reset_window_model();
    lvl_a_min = plwc_pkg::RST_A_MIN;
    lvl_b_min = plwc_pkg::RST_B_MIN;
    lvl_c_min = plwc_pkg::RST_C_MIN;
    lvl_d_min = plwc_pkg::RST_D_MIN;
    lvl_fault_max = plwc_pkg::RST_FAULT_MAX;
    repub_period = plwc_pkg::RST_REPUBLISH;
    foreach (level_count[i]) level_count[i] = 0;
    window_fill = 0;
    held_state = plwc_pkg::CLS_T;
    last_sent = plwc_pkg::CLS_A;
    published = 1'b0;
    repub_count = '0;
  endfunction

  // descending tests, first match wins whatever the register order
  function automatic plwc_pkg::class_t level_of(logic [7:0] v);
    if (v >= lvl_a_min) return plwc_pkg::CLS_A;
    if (v >= lvl_b_min) return plwc_pkg::CLS_B;
    if (v >= lvl_c_min) return plwc_pkg::CLS_C;
    if (v >= lvl_d_min) return plwc_pkg::CLS_D;
    if (v <= lvl_fault_max) return plwc_pkg::CLS_F;
    return plwc_pkg::CLS_T;
  endfunction

  function automatic plwc_pkg::class_t window_verdict();
    int mid;
    mid = level_count[plwc_pkg::CLS_B] + level_count[plwc_pkg::CLS_C] +
          level_count[plwc_pkg::CLS_D];
    // rail-to-rail swing with nothing in between
    if (mid == 0 && level_count[plwc_pkg::CLS_A] > 0 && level_count[plwc_pkg::CLS_F] > 0)
      return plwc_pkg::CLS_T;
    for (int s = plwc_pkg::CLS_A; s < plwc_pkg::CLS_T; s++) begin
      if (level_count[s] >= MAJORITY) return plwc_pkg::class_t'(s);
    end
    return held_state;
  endfunction

  function automatic void track_sample(logic [7:0] v);
    pilot_report_t rpt;
    level_count[level_of(v)]++;
    window_fill++;
    if (window_fill < WINDOW) return;
    held_state = window_verdict();
    foreach (level_count[i]) level_count[i] = 0;
    window_fill = 0;
    if (!published || held_state != last_sent) begin
      // sent on change, republish count is neither cleared nor advanced
      rpt.state = held_state;
      rpt.periodic = 1'b0;
      reports_due.push_back(rpt);
      last_sent = held_state;
      published = 1'b1;
    end else begin
      repub_count = repub_count + 6'd1;
      if (repub_count >= repub_period) begin
        rpt.state = held_state;
        rpt.periodic = 1'b1;
        reports_due.push_back(rpt);
        repub_count = '0;
      end
    end
  endfunction

  function automatic logic [7:0] pick_in_class(plwc_pkg::class_t k);
    int start;
    logic [7:0] v;
    start = $urandom_range(0, 255);
    for (int i = 0; i < 256; i++) begin
      v = 8'(start + i);
      if (level_of(v) == k) return v;
    end
    return 8'(start);
  endfunction

  // ---------------------------------------------------------------------------
  // result checking

  function automatic void log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    pilot_report_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        log_mismatch($sformatf("unexpected report: state %0d periodic %0b",
                               out_pilot_state, out_periodic));
      end else begin
        due = reports_due.pop_front();
        if (out_pilot_state !== due.state || out_periodic !== due.periodic) begin
          log_mismatch($sformatf(
              "report mismatch: expected state %0d periodic %0b, got state %0d periodic %0b",
              due.state, due.periodic, out_pilot_state, out_periodic));
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // watchdog on cycles without any transaction
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers, all entered and left at a falling edge

  task automatic send_sample(input logic [7:0] v);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (in_stall);
    track_sample(v);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      plwc_pkg::REG_A_MIN:     lvl_a_min = data;
      plwc_pkg::REG_B_MIN:     lvl_b_min = data;
      plwc_pkg::REG_C_MIN:     lvl_c_min = data;
      plwc_pkg::REG_D_MIN:     lvl_d_min = data;
      plwc_pkg::REG_FAULT_MAX: lvl_fault_max = data;
      plwc_pkg::REG_REPUBLISH: repub_period = data[5:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_levels(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                            input logic [7:0] d, input logic [7:0] f);
    write_reg(plwc_pkg::REG_A_MIN, a);
    write_reg(plwc_pkg::REG_B_MIN, b);
    write_reg(plwc_pkg::REG_C_MIN, c);
    write_reg(plwc_pkg::REG_D_MIN, d);
    write_reg(plwc_pkg::REG_FAULT_MAX, f);
  endtask

  // wait for every pending report, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_window(input window_shape_t shape, input plwc_pkg::class_t k,
                             input int n);
    logic [7:0] vals [WINDOW];
    logic [7:0] swap;
    int j;
    int roll;
    for (int i = 0; i < WINDOW; i++) begin
      case (shape)
        WIN_MAJORITY: vals[i] = (i < n) ? pick_in_class(k) : 8'($urandom_range(0, 255));
        WIN_RAIL, WIN_RAIL_BROKEN: begin
          roll = $urandom_range(0, 3);
          if (i == 0 || (i > 1 && roll < 2)) vals[i] = pick_in_class(plwc_pkg::CLS_A);
          else if (i == 1 || roll == 2) vals[i] = pick_in_class(plwc_pkg::CLS_F);
          else vals[i] = pick_in_class(plwc_pkg::CLS_T);
        end
        default: vals[i] = 8'($urandom_range(0, 255));
      endcase
    end
    // one mid-level sample spoils the rail-to-rail rule
    if (shape == WIN_RAIL_BROKEN)
      vals[2] = pick_in_class(plwc_pkg::class_t'($urandom_range(1, 3)));
    for (int i = WINDOW - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = vals[i];
      vals[i] = vals[j];
      vals[j] = swap;
    end
    for (int i = 0; i < WINDOW; i++) send_sample(vals[i]);
  endtask

  task automatic send_random_window();
    int roll;
    window_shape_t shape;
    roll = $urandom_range(0, 9);
    if (roll < 5) shape = WIN_MAJORITY;
    else if (roll < 7) shape = WIN_RAIL;
    else if (roll < 8) shape = WIN_RAIL_BROKEN;
    else shape = WIN_NOISE;
    send_window(shape, plwc_pkg::class_t'($urandom_range(0, 5)), $urandom_range(10, 16));
  endtask

  // ---------------------------------------------------------------------------
  // tests

  // every class edge at reset thresholds, no majority so the first window holds transient
  task automatic test_level_boundaries();
    logic [7:0] edges [WINDOW] = '{8'd255, 8'd0, 8'd232, 8'd231, 8'd207, 8'd206,
                                   8'd188, 8'd187, 8'd170, 8'd169, 8'd104, 8'd105,
                                   8'd128, 8'd233, 8'd1, 8'd254};
    foreach (edges[i]) send_sample(edges[i]);
    settle();
  endtask

  // exactly the majority count of C at its lowest level
  task automatic test_majority_threshold();
    for (int i = 0; i < WINDOW; i++) send_sample((i < MAJORITY) ? lvl_c_min : 8'd0);
    settle();
  endtask

  // every index, spare ones included, and a republish value with high bits set
  task automatic test_register_writes();
    set_levels(8'd240, 8'd200, 8'd160, 8'd120, 8'd60);
    write_reg(plwc_pkg::REG_REPUBLISH, 8'hC2);
    write_reg(REG_SPARE_6, 8'h00);
    write_reg(REG_SPARE_7, 8'hFF);
    repeat (4) send_random_window();
    settle();
  endtask

  task automatic test_threshold_extremes();
    // everything classifies as A, resend on every unchanged window
    set_levels(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    write_reg(plwc_pkg::REG_REPUBLISH, 8'd0);
    repeat (2) send_random_window();
    settle();
    // only full scale is A, the rest falls to fault
    set_levels(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    write_reg(plwc_pkg::REG_REPUBLISH, 8'd1);
    repeat (2) send_random_window();
    settle();
    // ascending thresholds, A test shadows the rest
    set_levels(8'd10, 8'd50, 8'd100, 8'd150, 8'd200);
    repeat (2) send_random_window();
    settle();
    // unordered random thresholds
    set_levels(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
    repeat (2) send_random_window();
    settle();
  endtask

  task automatic test_republish_period();
    logic [7:0] periods [4] = '{8'd1, 8'd2, 8'd3, 8'd63};
    plwc_pkg::class_t k;
    set_levels(plwc_pkg::RST_A_MIN, plwc_pkg::RST_B_MIN, plwc_pkg::RST_C_MIN,
               plwc_pkg::RST_D_MIN, plwc_pkg::RST_FAULT_MAX);
    foreach (periods[p]) begin
      write_reg(plwc_pkg::REG_REPUBLISH, periods[p]);
      k = plwc_pkg::class_t'($urandom_range(0, 4));
      if (periods[p] == 8'd63) begin
        send_window(WIN_MAJORITY, k, WINDOW);
      end else begin
        // steady run, one change, then steady again
        repeat (3) send_window(WIN_MAJORITY, k, WINDOW);
        send_window(WIN_MAJORITY, plwc_pkg::class_t'((k + 1) % 5), WINDOW);
        send_window(WIN_MAJORITY, plwc_pkg::class_t'((k + 1) % 5), WINDOW);
      end
      settle();
    end
  endtask

  task automatic test_random_windows();
    logic [7:0] a, b, c, d;
    for (int phase = 0; phase < 2; phase++) begin
      a = 8'($urandom_range(200, 255));
      b = 8'($urandom_range(150, a));
      c = 8'($urandom_range(100, b));
      d = 8'($urandom_range(50, c));
      set_levels(a, b, c, d, 8'($urandom_range(0, d)));
      write_reg(plwc_pkg::REG_REPUBLISH, 8'($urandom_range(1, 6)));
      // first phase runs with no idling on either side
      steady_flow = (phase == 0);
      repeat (6) send_random_window();
      settle();
    end
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    steady_flow = 1'b0;
    mismatch_count = 0;
    reset_window_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_level_boundaries();
    test_majority_threshold();
    test_register_writes();
    test_threshold_extremes();
    test_republish_period();
    test_random_windows();
    settle();

    if (mismatch_count == 0 && reports_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/plwc_pkg.sv
src/plwc_classify.sv
src/plwc_decide.sv
src/pilot_level_window_classifier_unit.sv
sim/testbench.sv
